// ===== sv/keypad_threshold_window_alarm_core_defines.svh =====
// Assertion macros shared by the alarm core RTL.
`ifndef KEYPAD_THRESHOLD_WINDOW_ALARM_CORE_DEFINES_SVH
`define KEYPAD_THRESHOLD_WINDOW_ALARM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KPWA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KPWA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kpwa_pkg.sv =====
package kpwa_pkg;

  localparam int NUM_KEYS = 16;

  // Scan code of each key, row nibble then column nibble.
  localparam logic [7:0] KEY_SCAN [NUM_KEYS] = '{
    8'h7e, 8'h7d, 8'h7b, 8'h77, 8'hbe, 8'hbd, 8'hbb, 8'hb7,
    8'hde, 8'hdd, 8'hdb, 8'hd7, 8'hee, 8'hed, 8'heb, 8'he7
  };

  // ASCII code of each key; 'a'..'d' select one of the four limits.
  localparam logic [7:0] KEY_ASCII [NUM_KEYS] = '{
    8'h31, 8'h32, 8'h33, 8'h61, 8'h34, 8'h35, 8'h36, 8'h62,
    8'h37, 8'h38, 8'h39, 8'h63, 8'h30, 8'h2B, 8'h2D, 8'h64
  };

  localparam logic [7:0] ASCII_ZERO      = 8'h30;
  localparam logic [7:0] ASCII_MINUS     = 8'h2D;
  localparam logic [7:0] ASCII_STAR      = 8'h2A;
  localparam logic [7:0] ASCII_SEL_FIRST = 8'h61;
  localparam logic [7:0] ASCII_SEL_LAST  = 8'h64;

  // Limit selection codes.
  localparam logic [2:0] SEL_TEMP_MIN = 3'd0;
  localparam logic [2:0] SEL_TEMP_MAX = 3'd1;
  localparam logic [2:0] SEL_HUM_MIN  = 3'd2;
  localparam logic [2:0] SEL_HUM_MAX  = 3'd3;
  localparam logic [2:0] SEL_NONE     = 3'd4;

  // Key positions within one four-key transaction.
  localparam logic [1:0] POS_SELECT = 2'd0;
  localparam logic [1:0] POS_SIGN   = 2'd1;
  localparam logic [1:0] POS_TENS   = 2'd2;
  localparam logic [1:0] POS_UNITS  = 2'd3;

  // Alarm flag bit positions.
  localparam int FLAG_TEMP_LOW  = 0;
  localparam int FLAG_TEMP_HIGH = 1;
  localparam int FLAG_HUM_LOW   = 2;
  localparam int FLAG_HUM_HIGH  = 3;

  typedef struct packed {
    logic       known;
    logic [7:0] ascii;
  } key_t;

  typedef struct packed {
    logic [3:0][7:0] tens;
    logic [3:0][7:0] units;
    logic [1:0]      neg;
  } limits_t;

  function automatic key_t decode_key(input logic [7:0] code);
    key_t k;
    k.known = 1'b0;
    k.ascii = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (code == KEY_SCAN[i]) begin
        k.known = 1'b1;
        k.ascii = KEY_ASCII[i];
      end
    end
    return k;
  endfunction

endpackage

// ===== sv/kpwa_ifs.sv =====
interface kpwa_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [7:0]         scan_code;
  logic signed [15:0] temperature;
  logic signed [15:0] humidity;

  modport source (output valid, action, scan_code, temperature, humidity, input ready);
  modport sink   (input valid, action, scan_code, temperature, humidity, output ready);
endinterface

interface kpwa_out_if;
  logic       valid;
  logic       ready;
  logic       temp_low_alarm;
  logic       temp_high_alarm;
  logic       hum_low_alarm;
  logic       hum_high_alarm;
  logic       buzzer_on;
  logic [1:0] entry_position;

  modport source (output valid, temp_low_alarm, temp_high_alarm, hum_low_alarm,
                  hum_high_alarm, buzzer_on, entry_position, input ready);
  modport sink   (input valid, temp_low_alarm, temp_high_alarm, hum_low_alarm,
                  hum_high_alarm, buzzer_on, entry_position, output ready);
endinterface

// ===== sv/keypad_threshold_window_alarm_core.sv =====
// Pipeline: an accepted item passes through the input stage and then the result stage.
// Throughput: one item per cycle while results are taken; the decode/compare between the input
//   register and the result register is combinational, and the result register frees on take.
// Reset: synchronous, active high; clears both stages, the alarm flags and the key position,
//   and loads the default limits (150, 250, 550, 750; all positive).
`include "keypad_threshold_window_alarm_core_defines.svh"

module keypad_threshold_window_alarm_core (
  input logic        clk,
  input logic        rst,
  kpwa_in_if.sink    sample,
  kpwa_out_if.source result
);

  // Input stage: hold one accepted item while it is decoded and compared.
  logic               stage_valid;
  logic               stage_action;
  logic [7:0]         stage_scan;
  logic signed [15:0] stage_temp;
  logic signed [15:0] stage_hum;

  // Result stage.
  logic               res_valid;
  logic [3:0]         res_flags;
  logic               res_buzzer;
  logic [1:0]         res_pos;

  logic [3:0]         alarm_flags;
  logic [3:0]         cmp_flags;
  logic [3:0]         flags_after;
  logic [1:0]         pos_after;
  logic               advance;
  logic               fire;
  kpwa_pkg::limits_t  lim;

  // Advance the input stage whenever the result register is free or being taken.
  assign advance      = !res_valid || result.ready;
  assign fire         = stage_valid && advance;
  assign sample.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample.ready) begin
      stage_valid <= sample.valid;
    end
  end

  // Payload of the input stage: no reset needed.
  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      stage_action <= sample.action;
      stage_scan   <= sample.scan_code;
      stage_temp   <= sample.temperature;
      stage_hum    <= sample.humidity;
    end
  end

  // Key decode and limit storage; updates on a key press leaving the input stage.
  kpwa_limits u_limits (
    .clk       (clk),
    .rst       (rst),
    .press     (fire && !stage_action),
    .scan_code (stage_scan),
    .lim       (lim),
    .pos_after (pos_after)
  );

  // Window compare against the stored limits.
  kpwa_cmp u_cmp (
    .lim         (lim),
    .temperature (stage_temp),
    .humidity    (stage_hum),
    .flags       (cmp_flags)
  );

  // A compare replaces the flags; a key press repeats the last ones.
  assign flags_after = stage_action ? cmp_flags : alarm_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_flags <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (fire) begin
        alarm_flags <= flags_after;
      end
      if (advance) begin
        res_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_flags  <= flags_after;
      res_buzzer <= |flags_after;
      res_pos    <= pos_after;
    end
  end

  assign result.valid           = res_valid;
  assign result.temp_low_alarm  = res_flags[kpwa_pkg::FLAG_TEMP_LOW];
  assign result.temp_high_alarm = res_flags[kpwa_pkg::FLAG_TEMP_HIGH];
  assign result.hum_low_alarm   = res_flags[kpwa_pkg::FLAG_HUM_LOW];
  assign result.hum_high_alarm  = res_flags[kpwa_pkg::FLAG_HUM_HIGH];
  assign result.buzzer_on       = res_buzzer;
  assign result.entry_position  = res_pos;

  `KPWA_ASSERT_NEXT(a_press_keeps_flags, clk, rst, fire && !stage_action, alarm_flags == $past(alarm_flags), "key press changed the alarm flags")
  `KPWA_ASSERT_NEXT(a_fire_gives_result, clk, rst, fire, res_valid, "item left the input stage without a result")
  `KPWA_ASSERT_IMPL(a_full_blocks_input, clk, rst, stage_valid && res_valid && !result.ready, !sample.ready, "input taken while both stages are full")
  `KPWA_ASSERT_IMPL(a_result_matches_flags, clk, rst, res_valid, res_flags == alarm_flags, "result flags differ from stored flags")

endmodule

// ===== sv/kpwa_limits.sv =====
`include "keypad_threshold_window_alarm_core_defines.svh"

module kpwa_limits (
  input  logic              clk,
  input  logic              rst,
  input  logic              press,
  input  logic [7:0]        scan_code,
  output kpwa_pkg::limits_t lim,
  output logic [1:0]        pos_after
);

  logic [1:0]        key_position;
  logic [2:0]        selected_limit;
  kpwa_pkg::key_t    key;
  logic              take;
  logic              is_select;
  logic [2:0]        sel_code;

  always_comb begin
    key       = kpwa_pkg::decode_key(scan_code);
    take      = press && key.known;
    is_select = (key.ascii >= kpwa_pkg::ASCII_SEL_FIRST) &&
                (key.ascii <= kpwa_pkg::ASCII_SEL_LAST);
    sel_code  = 3'(key.ascii - kpwa_pkg::ASCII_SEL_FIRST);
    pos_after = take ? key_position + 2'd1 : key_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position   <= kpwa_pkg::POS_SELECT;
      selected_limit <= kpwa_pkg::SEL_NONE;
      lim.tens[0]    <= 8'h31;
      lim.tens[1]    <= 8'h32;
      lim.tens[2]    <= 8'h35;
      lim.tens[3]    <= 8'h37;
      lim.units      <= {4{8'h35}};
      lim.neg        <= 2'b00;
    end else if (take) begin
      key_position <= key_position + 2'd1;
      unique case (key_position)
        kpwa_pkg::POS_SELECT: begin
          if (is_select) begin
            selected_limit              <= sel_code;
            lim.tens[sel_code[1:0]]     <= kpwa_pkg::ASCII_STAR;
            lim.units[sel_code[1:0]]    <= kpwa_pkg::ASCII_STAR;
            if (!sel_code[1]) begin
              lim.neg[sel_code[0]] <= 1'b0;
            end
          end else begin
            selected_limit <= kpwa_pkg::SEL_NONE;
          end
        end
        kpwa_pkg::POS_SIGN: begin
          // Humidity limits stay positive.
          if (selected_limit == kpwa_pkg::SEL_TEMP_MIN ||
              selected_limit == kpwa_pkg::SEL_TEMP_MAX) begin
            lim.neg[selected_limit[0]] <= (key.ascii == kpwa_pkg::ASCII_MINUS);
          end
        end
        kpwa_pkg::POS_TENS: begin
          if (!selected_limit[2]) begin
            lim.tens[selected_limit[1:0]] <= key.ascii;
          end
        end
        kpwa_pkg::POS_UNITS: begin
          if (!selected_limit[2]) begin
            lim.units[selected_limit[1:0]] <= key.ascii;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `KPWA_ASSERT_NEXT(a_pos_hold_no_press, clk, rst, !take, $stable(key_position), "key position moved without a known key")
  `KPWA_ASSERT_NEXT(a_pos_step, clk, rst, take, key_position == $past(key_position) + 2'd1, "key position did not advance by one")
  `KPWA_ASSERT_IMPL(a_sel_range, clk, rst, 1'b1, selected_limit <= kpwa_pkg::SEL_NONE, "selected limit out of range")

endmodule

// ===== sv/kpwa_cmp.sv =====
module kpwa_cmp (
  input  kpwa_pkg::limits_t  lim,
  input  logic signed [15:0] temperature,
  input  logic signed [15:0] humidity,
  output logic [3:0]         flags
);

  logic signed [16:0] lval [4];
  logic signed [16:0] temp_ext;
  logic signed [16:0] hum_ext;

  function automatic logic signed [16:0] limit_value(input logic [7:0] tens,
                                                    input logic [7:0] units,
                                                    input logic       neg);
    logic signed [8:0]  t;
    logic signed [8:0]  u;
    logic signed [16:0] te;
    logic signed [16:0] ue;
    logic signed [16:0] v;
    t  = $signed({1'b0, tens}) - $signed({1'b0, kpwa_pkg::ASCII_ZERO});
    u  = $signed({1'b0, units}) - $signed({1'b0, kpwa_pkg::ASCII_ZERO});
    te = 17'(t);
    ue = 17'(u);
    v  = te * 17'sd100 + ue * 17'sd10;
    return neg ? -v : v;
  endfunction

  always_comb begin
    lval[0]  = limit_value(lim.tens[0], lim.units[0], lim.neg[0]);
    lval[1]  = limit_value(lim.tens[1], lim.units[1], lim.neg[1]);
    lval[2]  = limit_value(lim.tens[2], lim.units[2], 1'b0);
    lval[3]  = limit_value(lim.tens[3], lim.units[3], 1'b0);
    temp_ext = 17'(temperature);
    hum_ext  = 17'(humidity);
    flags[kpwa_pkg::FLAG_TEMP_LOW]  = temp_ext < lval[0];
    flags[kpwa_pkg::FLAG_TEMP_HIGH] = temp_ext > lval[1];
    flags[kpwa_pkg::FLAG_HUM_LOW]   = hum_ext < lval[2];
    flags[kpwa_pkg::FLAG_HUM_HIGH]  = hum_ext > lval[3];
  end

endmodule
